// ===== rtl/cpbo_pkg.sv =====
`default_nettype none
package cpbo_pkg;

  localparam int FRAC_BITS = 8;
  localparam int STEP_FRAC = 16;

  localparam int SPD_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = SPD_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DERIV_W = DIFF_W + GAIN_W - FRAC_BITS + 1;
  localparam int MUL_A_W = DERIV_W;
  localparam int PROD_W  = MUL_A_W + GAIN_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int CMP_W   = 32;
  localparam int THR_W   = 15;
  localparam int BRK_W   = 14;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = CFG_IDX_W'(5);

  localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = GAIN_W'(512);
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = GAIN_W'(128);
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = GAIN_W'(26);
  localparam logic [GAIN_W-1:0] RST_STEP_TIME  = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0] RST_INV_STEP   = GAIN_W'(2560);
  localparam logic [GAIN_W-1:0] RST_INTEG_LIM  = GAIN_W'(25600);

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] step_time;
    logic [GAIN_W-1:0] inv_step_time;
    logic [GAIN_W-1:0] integ_limit;
  } cfg_t;

  typedef struct packed {
    logic [SPD_W-1:0] set_speed;
    logic [SPD_W-1:0] measured_speed;
    logic             cruise_on;
  } in_t;

  typedef struct packed {
    logic [THR_W-1:0] throttle_out;
    logic [BRK_W-1:0] brake_cmd;
    logic             cmd_valid;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/cpbo_cfg.sv =====
`default_nettype none
module cpbo_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [cpbo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpbo_pkg::GAIN_W-1:0]        cfg_data,
  output cpbo_pkg::cfg_t                          cfg_o
);
  import cpbo_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= RST_PROP_GAIN;
      cfg_r.integ_gain    <= RST_INTEG_GAIN;
      cfg_r.deriv_gain    <= RST_DERIV_GAIN;
      cfg_r.step_time     <= RST_STEP_TIME;
      cfg_r.inv_step_time <= RST_INV_STEP;
      cfg_r.integ_limit   <= RST_INTEG_LIM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:  cfg_r.prop_gain     <= cfg_data;
        REG_INTEG_GAIN: cfg_r.integ_gain    <= cfg_data;
        REG_DERIV_GAIN: cfg_r.deriv_gain    <= cfg_data;
        REG_STEP_TIME:  cfg_r.step_time     <= cfg_data;
        REG_INV_STEP:   cfg_r.inv_step_time <= cfg_data;
        REG_INTEG_LIM:  cfg_r.integ_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

// ===== rtl/cpbo_mul.sv =====
`default_nettype none
module cpbo_mul (
  input  wire logic                                clk,
  input  wire logic signed [cpbo_pkg::MUL_A_W-1:0] mul_a,
  input  wire logic        [cpbo_pkg::GAIN_W-1:0]  mul_b,
  output logic signed      [cpbo_pkg::PROD_W-1:0]  prod_r
);
  import cpbo_pkg::*;

  logic signed [GAIN_W:0]   b_s;
  logic signed [PROD_W-1:0] prod_nxt;

  assign b_s      = signed'({1'b0, mul_b});
  assign prod_nxt = mul_a * b_s;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/cpbo_core.sv =====
`default_nettype none
module cpbo_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire cpbo_pkg::cfg_t                      cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cpbo_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cpbo_pkg::out_t                           out_data,
  output logic signed [cpbo_pkg::MUL_A_W-1:0]      mul_a,
  output logic        [cpbo_pkg::GAIN_W-1:0]       mul_b,
  input  wire logic signed [cpbo_pkg::PROD_W-1:0]  prod_r
);
  import cpbo_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_INC  = 9'b000000010,
    S_DIF  = 9'b000000100,
    S_PRP  = 9'b000001000,
    S_INT  = 9'b000010000,
    S_DER  = 9'b000100000,
    S_SUM  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  localparam logic signed [ACC_W-1:0] THR_MAX  = ACC_W'(100 << FRAC_BITS);
  localparam logic signed [CMP_W-1:0] BRK_TRIP = -CMP_W'(10 << FRAC_BITS);
  localparam logic signed [CMP_W-1:0] BRK_MAX  = CMP_W'(50 << FRAC_BITS);
  localparam logic signed [PROD_W:0]  HALF_STEP = (PROD_W+1)'(1 << (STEP_FRAC - 1));
  localparam logic signed [PROD_W:0]  HALF_FRAC = (PROD_W+1)'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] HALF_ACC  = ACC_W'(1 << (FRAC_BITS - 1));

  state_t state_r, state_nxt;

  logic signed [ERR_W-1:0]   err_r, integ_accum_r, last_err_r, integ_r;
  logic signed [DERIV_W-1:0] deriv_r;
  logic signed [ACC_W-1:0]   acc_r;
  out_t                      res_r;
  out_t                      out_r;
  logic                      out_valid_r;

  logic signed [ERR_W-1:0]  err_in;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W:0]   prod_x, inc_full, der_full;
  logic signed [ERR_W:0]    inc;
  logic signed [ERR_W+1:0]  isum, lim_pos, lim_neg;
  logic signed [ERR_W-1:0]  integ_nxt;
  logic signed [ACC_W-1:0]  prod_acc, thr_full, thr_s, thr_c;
  logic signed [CMP_W-1:0]  err32, brk_raw, brk_c;
  logic                     brake_on;
  logic                     out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign err_in = signed'({1'b0, in_data.set_speed}) - signed'({1'b0, in_data.measured_speed});
  assign diff   = DIFF_W'(err_r) - DIFF_W'(last_err_r);

  assign prod_x   = {prod_r[PROD_W-1], prod_r};
  assign prod_acc = ACC_W'(prod_r);
  assign inc_full = prod_x + HALF_STEP;
  assign inc      = inc_full[STEP_FRAC+ERR_W:STEP_FRAC];
  assign isum     = (ERR_W+2)'(integ_accum_r) + (ERR_W+2)'(inc);
  assign lim_pos  = signed'({3'b000, cfg.integ_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (isum > lim_pos) begin
      integ_nxt = lim_pos[ERR_W-1:0];
    end else if (isum < lim_neg) begin
      integ_nxt = lim_neg[ERR_W-1:0];
    end else begin
      integ_nxt = isum[ERR_W-1:0];
    end
  end

  assign der_full = prod_x + HALF_FRAC;

  assign thr_full = acc_r + HALF_ACC;
  assign thr_s    = thr_full >>> FRAC_BITS;

  always_comb begin
    if (thr_s < 0) begin
      thr_c = '0;
    end else if (thr_s > THR_MAX) begin
      thr_c = THR_MAX;
    end else begin
      thr_c = thr_s;
    end
  end

  assign err32    = CMP_W'(err_r);
  assign brake_on = (err32 < BRK_TRIP);
  assign brk_raw  = -(err32 <<< 1);
  assign brk_c    = (brk_raw > BRK_MAX) ? BRK_MAX : brk_raw;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_INC: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = cfg.step_time;
      end
      S_DIF: begin
        mul_a = MUL_A_W'(diff);
        mul_b = cfg.inv_step_time;
      end
      S_PRP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = cfg.prop_gain;
      end
      S_INT: begin
        mul_a = MUL_A_W'(integ_r);
        mul_b = cfg.integ_gain;
      end
      S_DER: begin
        mul_a = deriv_r;
        mul_b = cfg.deriv_gain;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cruise_on && (in_data.set_speed != '0)) begin
            state_nxt = S_INC;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_INC: state_nxt = S_DIF;
      S_DIF: state_nxt = S_PRP;
      S_PRP: state_nxt = S_INT;
      S_INT: state_nxt = S_DER;
      S_DER: state_nxt = S_SUM;
      S_SUM: state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      integ_accum_r <= '0;
      last_err_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_FIN) begin
        integ_accum_r <= integ_r;
        last_err_r    <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        err_r <= err_in;
        res_r <= '0;
      end
      S_DIF: integ_r <= integ_nxt;
      S_PRP: deriv_r <= der_full[FRAC_BITS+DERIV_W-1:FRAC_BITS];
      S_INT: acc_r   <= prod_acc;
      S_DER: acc_r   <= acc_r + prod_acc;
      S_SUM: acc_r   <= acc_r + prod_acc;
      S_FIN: begin
        res_r.cmd_valid <= 1'b1;
        if (brake_on) begin
          res_r.throttle_out <= '0;
          res_r.brake_cmd    <= brk_c[BRK_W-1:0];
        end else begin
          res_r.throttle_out <= thr_c[THR_W-1:0];
          res_r.brake_cmd    <= '0;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_r <= res_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/cruise_pid_with_brake_override.sv =====
// Cruise-control PID with brake override.
// Input channel (in_valid/in_ready/in_data): one control tick per transaction,
// target and measured speed (unsigned Q8.8) plus the cruise_on flag.
// Output channel (out_valid/out_ready/out_data): exactly one result per tick,
// throttle_out, brake_cmd and cmd_valid (0 for a disabled tick).
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): gain and timing
// registers, always ready; unknown indexes are dropped.
// Sequencing: an enabled tick steps from acceptance through S_INC, S_DIF,
// S_PRP, S_INT, S_DER, S_SUM and S_FIN to S_OUT, making five passes through
// the single shared 27x17 multiplier plus setup, clamp and output steps; a
// disabled tick goes straight to S_OUT. No new tick is taken mid-sequence;
// in_ready is high only while the sequencer is idle.
// The result register lets a new tick be accepted while the previous result
// waits; if the receiver stalls, the next result holds in the sequencer until
// the output register frees up.
// Reset (rst_n, synchronous): registers return to defaults, the integral and
// last error clear, and no result is pending.
`default_nettype none
module cruise_pid_with_brake_override (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire cpbo_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output cpbo_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cpbo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpbo_pkg::GAIN_W-1:0]     cfg_data
);
  import cpbo_pkg::*;

  cfg_t                      cfg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [GAIN_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  assign cfg_ready = 1'b1;

  cpbo_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  cpbo_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  cpbo_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .prod_r    (prod_r)
  );

endmodule
`default_nettype wire
